// ===== src/hce_pkg.sv =====
// Shared constants, types and helper functions for the Hill cipher encryption block.
package hce_pkg;

  localparam int MaxBlock = 4;
  localparam int KeyDim = 4;
  localparam int BlockLim = (MaxBlock < KeyDim) ? MaxBlock : KeyDim;

  localparam int CharW = 8;
  localparam int LetterW = 5;
  localparam int CipherW = 7;
  localparam int SizeW = 3;
  localparam int RowW = 2;
  localparam int KeyW = KeyDim * LetterW;
  localparam int ProdW = 2 * LetterW;
  localparam int SumW = 12;
  localparam int QuotW = 7;
  localparam int CfgIdxW = 3;

  localparam int Modulus = 26;
  localparam int RecipShift = 16;
  localparam int ModRecip = ((1 << RecipShift) + Modulus - 1) / Modulus;
  localparam int RecipW = 12;

  localparam logic [CharW-1:0] AsciiA = 8'd97;
  localparam logic [CharW-1:0] AsciiZ = 8'd122;
  localparam logic [LetterW-1:0] PadLetter = 5'd25;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegBlockSize = 3'd0;
  localparam cfg_idx_t RegKeyRow0 = 3'd1;
  localparam cfg_idx_t RegKeyRow1 = 3'd2;
  localparam cfg_idx_t RegKeyRow2 = 3'd3;
  localparam cfg_idx_t RegKeyRow3 = 3'd4;

  localparam logic [SizeW-1:0] BlockSizeReset = 3'd2;
  localparam logic [KeyW-1:0] KeyRow0Reset = 20'd1;
  localparam logic [KeyW-1:0] KeyRow1Reset = 20'd32;
  localparam logic [KeyW-1:0] KeyRow2Reset = 20'd1024;
  localparam logic [KeyW-1:0] KeyRow3Reset = 20'd32768;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sum;
    logic div;
    logic out;
  } hce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic last_row;
    logic out_free;
  } hce_sts_t;

  // Block size in use: zero acts as one, anything above the limit acts as the limit.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] raw);
    logic [SizeW-1:0] s;
    s = raw;
    if (s == '0) s = SizeW'(1);
    if (s > SizeW'(BlockLim)) s = SizeW'(BlockLim);
    return s;
  endfunction

endpackage

// ===== src/hce_ctrl.sv =====
// Controller state machine that sequences item intake and the per-row cipher steps.
module hce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  hce_pkg::hce_sts_t sts,
  output hce_pkg::hce_cmd_t cmd
);
  import hce_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    s_tready   = (state == ST_IDLE);
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid && sts.emit) state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // Wait here while the previous letter still sits in the output register.
        if (sts.out_free) begin
          cmd.out    = 1'b1;
          state_next = sts.last_row ? ST_IDLE : ST_SUM;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

// ===== src/hce_dp.sv =====
// Datapath: configuration registers, letter buffer, row dot product, mod 26 and output register.
module hce_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  hce_pkg::cfg_idx_t                   cfg_index,
  input  logic [hce_pkg::KeyW-1:0]            cfg_data,
  input  logic [hce_pkg::CharW-1:0]           char_in,
  input  logic                                end_of_text,
  input  hce_pkg::hce_cmd_t                   cmd,
  output hce_pkg::hce_sts_t                   sts,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hce_pkg::CipherW-1:0]         cipher_letter,
  output logic                                last_of_block,
  output logic                                end_of_message
);
  import hce_pkg::*;

  logic [SizeW-1:0]   block_size;
  logic [KeyW-1:0]    key_row [KeyDim];
  logic [LetterW-1:0] letter_buffer [MaxBlock];
  logic [SizeW-1:0]   fill_count;
  logic [RowW-1:0]    row;
  logic               final_flag;
  logic [SumW-1:0]    acc;
  logic [QuotW-1:0]   quot;

  logic [SizeW-1:0]   size;
  logic [SizeW-1:0]   fc;
  logic [SizeW-1:0]   fc_new;
  logic               is_letter;
  logic               full;
  logic               pad;
  logic [CharW-1:0]   char_off;
  logic [KeyW-1:0]    key_sel;
  logic [SumW-1:0]    row_sum;
  logic [SumW+RecipW-1:0] quot_prod;
  logic [SumW-1:0]    rem_raw;
  logic [SumW-1:0]    rem;
  logic [CipherW-1:0] letter_code;

  assign size      = eff_size(block_size);
  assign fc        = (fill_count >= size) ? '0 : fill_count;
  assign is_letter = (char_in >= AsciiA) && (char_in <= AsciiZ);
  assign fc_new    = fc + SizeW'(is_letter);
  assign full      = is_letter && (fc_new >= size);
  assign pad       = !full && end_of_text && (fc_new != '0);
  assign char_off  = char_in - AsciiA;

  assign sts.emit     = full || pad;
  assign sts.last_row = ({1'b0, row} == (size - SizeW'(1)));
  assign sts.out_free = !m_tvalid || m_tready;

  // Dot product of the selected key row with the block; columns past the size are masked.
  assign key_sel = key_row[row];
  always_comb begin
    row_sum = '0;
    for (int c = 0; c < MaxBlock; c++) begin
      if (SizeW'(c) < size) begin
        row_sum = row_sum + SumW'(ProdW'(key_sel[LetterW*c +: LetterW]) *
                                  ProdW'(letter_buffer[c]));
      end
    end
  end

  // Reciprocal multiply gives the exact quotient for every sum this block can form.
  assign quot_prod   = SumW'(acc) * RecipW'(ModRecip);
  assign rem_raw     = acc - SumW'(quot * SumW'(Modulus));
  assign rem         = (rem_raw >= SumW'(Modulus)) ? rem_raw - SumW'(Modulus) : rem_raw;
  assign letter_code = CipherW'(rem) + CipherW'(AsciiA);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BlockSizeReset;
      key_row[0] <= KeyRow0Reset;
      key_row[1] <= KeyRow1Reset;
      key_row[2] <= KeyRow2Reset;
      key_row[3] <= KeyRow3Reset;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          RegBlockSize: begin
            block_size <= cfg_data[SizeW-1:0];
            fill_count <= '0;
          end
          RegKeyRow0: key_row[0] <= cfg_data;
          RegKeyRow1: key_row[1] <= cfg_data;
          RegKeyRow2: key_row[2] <= cfg_data;
          RegKeyRow3: key_row[3] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) fill_count <= sts.emit ? '0 : fc_new;
      if (cmd.out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row        <= '0;
      final_flag <= end_of_text;
      for (int i = 0; i < MaxBlock; i++) begin
        if (is_letter && (SizeW'(i) == fc)) begin
          letter_buffer[i] <= char_off[LetterW-1:0];
        end else if (pad && (SizeW'(i) >= fc_new) && (SizeW'(i) < size)) begin
          letter_buffer[i] <= PadLetter;
        end
      end
    end
    if (cmd.sum) acc <= row_sum;
    if (cmd.div) quot <= quot_prod[RecipShift +: QuotW];
    if (cmd.out) begin
      cipher_letter  <= letter_code;
      last_of_block  <= sts.last_row;
      end_of_message <= sts.last_row && final_flag;
      row            <= row + RowW'(1);
    end
  end

endmodule

// ===== src/hill_cipher_encrypt.sv =====
// Top level of the streaming Hill cipher encryption block (mod 26).
//
// Text bytes arrive on the s_ stream, one item per byte; s_tlast marks the final
// byte of a message. Bytes outside 'a'..'z' are dropped. Letters collect into a
// block of block_size letters (1..4, reset 2). A full block, or a partial block
// padded with 'z' at end of text, yields one ciphertext letter per key row on the
// m_ stream, m_tlast on the last letter of each block and m_tuser on the last
// letter of the message.
// An item that completes no block is accepted while the controller is idle. A
// completed block holds the input while each output letter goes through three
// controller steps: row dot product, reciprocal-multiply quotient, and
// remainder into the output register.
// The output register holds one letter; when the receiver stalls, the next
// letter waits in the datapath and intake stops until the last letter of the
// block is in the output register.
// Reset clears the fill count and output valid and loads block size 2 with an
// identity key. The configuration channel is always ready; writes belong to idle
// periods, and writing the block size discards a pending partial block.
module hill_cipher_encrypt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  hce_pkg::cfg_idx_t               cfg_index,
  input  logic [hce_pkg::KeyW-1:0]        cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] char_in
  input  logic                            s_tlast,  // end_of_text
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,  // [6:0] cipher_letter, [7] zero
  output logic                            m_tlast,  // last_of_block
  output logic                            m_tuser   // [0] end_of_message
);
  import hce_pkg::*;

  hce_cmd_t           cmd;
  hce_sts_t           sts;
  logic [CipherW-1:0] cipher_letter;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  hce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hce_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .char_in        (s_tdata),
    .end_of_text    (s_tlast),
    .cmd            (cmd),
    .sts            (sts),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .cipher_letter  (cipher_letter),
    .last_of_block  (m_tlast),
    .end_of_message (m_tuser)
  );

  assign m_tdata = {1'b0, cipher_letter};

  // The end of a message always closes a block.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tlast)
    else $error("end of message without end of block");

  // The remainder stage must always land on a lowercase letter.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] >= 7'd97) && (m_tdata[6:0] <= 7'd122))
    else $error("cipher letter out of range");

  // The controller loads the output register only once the held letter is gone.
  assert property (@(posedge clk) disable iff (rst) cmd.out |-> sts.out_free)
    else $error("output register overwritten");

  // No new text is taken while a block is being emitted.
  assert property (@(posedge clk) disable iff (rst) cmd.sum |-> !s_tready)
    else $error("intake open during block emission");

endmodule

// ===== sim/tb_hill_cipher_encrypt.sv =====
// Self-checking testbench for the streaming Hill cipher encryption block.
module tb_hill_cipher_encrypt;
  import hce_pkg::*;

  // Covers, with margin, the longest block's hold on the input and the path from
  // the item that closed a block to its first letter.
  localparam int IdlePause = 3 * BlockLim + 8;
  localparam int PhaseItems = 55;
  localparam int NumPhases = 6;
  localparam int ShownMismatches = 10;

  // One ciphertext letter as it should leave the master side.
  typedef struct packed {
    logic [CipherW-1:0] letter;
    logic               last_of_block;
    logic               end_of_msg;
  } cipher_out_t;

  // One row of the directed table: either a register write or a text byte. Rows
  // with typed letters carry the result in plain text, last letter first in the
  // low byte order of a string literal.
  typedef struct {
    bit               is_reg;
    cfg_idx_t         idx;
    logic [KeyW-1:0]  val;
    logic [CharW-1:0] ch;
    logic             eot;
    int               n_typed;
    logic [31:0]      typed_letters;
    logic             typed_eom;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_idx_t          cfg_index;
  logic [KeyW-1:0]   cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [7:0] char_in
  logic              s_tlast;   // end_of_text
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;   // [6:0] cipher_letter, [7] zero
  logic              m_tlast;   // last_of_block
  logic              m_tuser;   // [0] end_of_message

  hill_cipher_encrypt uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state: its own copy of the registers and the pending block.
  logic [SizeW-1:0]   size_reg;
  logic [KeyW-1:0]    key_row [KeyDim];
  logic [LetterW-1:0] held [MaxBlock];
  int                 fill;

  cipher_out_t cipher_due[$];   // letters still owed by the block, oldest first
  cipher_out_t fresh[$];        // letters caused by the item just accepted
  cipher_out_t head_due;

  int  mismatches = 0;
  int  items_sent = 0;
  int  letters_checked = 0;
  int  eom_seen = 0;
  logic [7:0] sizes_used = '0;
  bit  steady_send = 1'b0;
  bit  steady_take = 1'b0;
  int  stall_left = 0;
  int  rx_roll;

  stim_row_t dir_tab[$];

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= ShownMismatches) $display("MISMATCH: %s", msg);
  endtask

  function automatic cfg_idx_t key_reg(input int r);
    case (r)
      0: return RegKeyRow0;
      1: return RegKeyRow1;
      2: return RegKeyRow2;
      default: return RegKeyRow3;
    endcase
  endfunction

  // Zero behaves as one, and anything past the supported dimension is clamped.
  function automatic int active_size();
    int s;
    s = int'(size_reg);
    if (s == 0) s = 1;
    if (s > BlockLim) s = BlockLim;
    return s;
  endfunction

  // Multiplies the key by the held block, one output letter per key row.
  function automatic void close_block(input int size, input bit final_msg);
    int acc;
    cipher_out_t o;
    for (int r = 0; r < size; r++) begin
      acc = 0;
      for (int c = 0; c < size; c++)
        acc += int'(key_row[r][LetterW*c +: LetterW]) * int'(held[c]);
      o.letter = CipherW'(acc % Modulus + int'(AsciiA));
      o.last_of_block = (r == size - 1);
      o.end_of_msg = final_msg && (r == size - 1);
      fresh.push_back(o);
    end
    fill = 0;
  endfunction

  function automatic void encipher_item(input logic [CharW-1:0] ch, input logic eot);
    int size;
    size = active_size();
    fresh.delete();
    if (fill >= size) fill = 0;
    if (ch >= AsciiA && ch <= AsciiZ) begin
      held[fill] = LetterW'(ch - AsciiA);
      fill++;
      if (fill >= size) begin
        // A letter that fills the block wins over the padding path.
        close_block(size, eot);
        return;
      end
    end
    if (eot && fill > 0) begin
      for (int i = fill; i < size; i++) held[i] = PadLetter;
      close_block(size, 1'b1);
    end
  endfunction

  function automatic void load_reg(input cfg_idx_t idx, input logic [KeyW-1:0] val);
    case (idx)
      RegBlockSize: begin
        size_reg = val[SizeW-1:0];
        fill = 0;
        sizes_used[val[SizeW-1:0]] = 1'b1;
      end
      RegKeyRow0: key_row[0] = val;
      RegKeyRow1: key_row[1] = val;
      RegKeyRow2: key_row[2] = val;
      RegKeyRow3: key_row[3] = val;
      default: ;
    endcase
  endfunction

  function automatic stim_row_t row_reg(input cfg_idx_t idx, input logic [KeyW-1:0] val);
    stim_row_t t;
    t = '{default: '0};
    t.is_reg = 1'b1;
    t.idx = idx;
    t.val = val;
    return t;
  endfunction

  function automatic stim_row_t row_item(input logic [CharW-1:0] ch, input logic eot);
    stim_row_t t;
    t = '{default: '0};
    t.ch = ch;
    t.eot = eot;
    return t;
  endfunction

  function automatic stim_row_t row_check(input logic [CharW-1:0] ch, input logic eot,
                                          input int n, input logic [31:0] letters,
                                          input logic eom);
    stim_row_t t;
    t = row_item(ch, eot);
    t.n_typed = n;
    t.typed_letters = letters;
    t.typed_eom = eom;
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Presents one text byte and waits for the handshake. valid is only lowered when
  // a gap precedes the item, so back-to-back items keep it high.
  task automatic send_item(input logic [CharW-1:0] ch, input logic eot, input bit typed_row);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= eot;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    encipher_item(ch, eot);
    if (!typed_row)
      foreach (fresh[i]) cipher_due.push_back(fresh[i]);
  endtask

  task automatic stop_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Waits until every owed letter has been delivered, then lets a trailing item
  // that caused no result finish inside the block.
  task automatic settle();
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (IdlePause) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [KeyW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    load_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: mostly ready, with short stalls, occasional long ones and stretches
  // of continuous acceptance.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) steady_take = !steady_take;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (steady_take) begin
      m_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 65) begin
        m_tready <= 1'b1;
      end else if (rx_roll < 95) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(9, 29);
      end
    end
  end

  // Every accepted letter is compared with the oldest owed one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      letters_checked++;
      if (m_tuser === 1'b1) eom_seen++;
      if (cipher_due.size() == 0) begin
        note_mismatch($sformatf("letter %0d: none owed, got tdata %h tlast %b tuser %b",
                                letters_checked, m_tdata, m_tlast, m_tuser));
      end else begin
        head_due = cipher_due.pop_front();
        if (m_tdata !== {1'b0, head_due.letter} || m_tlast !== head_due.last_of_block ||
            m_tuser !== head_due.end_of_msg)
          note_mismatch($sformatf(
            "letter %0d: expected tdata %h tlast %b tuser %b, got %h %b %b",
            letters_checked, {1'b0, head_due.letter}, head_due.last_of_block,
            head_due.end_of_msg, m_tdata, m_tlast, m_tuser));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d letters still owed", cipher_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [CharW-1:0] ch;
    logic             eot;
    logic [KeyW-1:0]  kv;
    stim_row_t        t;
    cipher_out_t      o;
    int               counted;
    int               pick;
    bit               held_off;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegBlockSize;
    cfg_data = '0;

    size_reg = BlockSizeReset;
    key_row[0] = KeyRow0Reset;
    key_row[1] = KeyRow1Reset;
    key_row[2] = KeyRow2Reset;
    key_row[3] = KeyRow3Reset;
    for (int i = 0; i < MaxBlock; i++) held[i] = '0;
    fill = 0;
    sizes_used[BlockSizeReset] = 1'b1;

    // Directed part. After reset the key is the identity and blocks hold two
    // letters, so plain text comes back unchanged and padding shows up as 'z'.
    dir_tab.push_back(row_item("a", 1'b0));
    dir_tab.push_back(row_check("z", 1'b0, 2, "az", 1'b0));
    dir_tab.push_back(row_item(8'h00, 1'b0));
    // End of text with nothing pending produces nothing.
    dir_tab.push_back(row_item(8'hFF, 1'b1));
    dir_tab.push_back(row_item(8'h60, 1'b0));            // just below 'a'
    dir_tab.push_back(row_item(8'h7B, 1'b0));            // just above 'z'
    // A letter with end of text that leaves the block partial gets padded.
    dir_tab.push_back(row_check("q", 1'b1, 2, "qz", 1'b1));
    dir_tab.push_back(row_item("m", 1'b0));
    // A letter with end of text that completes the block ends the message.
    dir_tab.push_back(row_check("n", 1'b1, 2, "mn", 1'b1));
    dir_tab.push_back(row_item("c", 1'b0));
    // A dropped byte that carries end of text still flushes the pending letter.
    dir_tab.push_back(row_check(8'h80, 1'b1, 2, "cz", 1'b1));
    // A block size write throws away the pending 'd'.
    dir_tab.push_back(row_item("d", 1'b0));
    dir_tab.push_back(row_reg(RegBlockSize, KeyW'(3)));
    dir_tab.push_back(row_item("a", 1'b0));
    dir_tab.push_back(row_item("b", 1'b0));
    dir_tab.push_back(row_check("c", 1'b0, 3, "abc", 1'b0));
    // Size zero acts as one letter per block.
    dir_tab.push_back(row_reg(RegBlockSize, KeyW'(0)));
    dir_tab.push_back(row_check("k", 1'b0, 1, "k", 1'b0));
    dir_tab.push_back(row_check("x", 1'b1, 1, "x", 1'b1));
    // Size seven acts as four; key entries of 31 stay unreduced until the sum.
    dir_tab.push_back(row_reg(RegBlockSize, KeyW'(7)));
    for (int r = 0; r < KeyDim; r++) dir_tab.push_back(row_reg(key_reg(r), 20'hFFFFF));
    dir_tab.push_back(row_item("a", 1'b1));
    for (int i = 0; i < 4; i++) dir_tab.push_back(row_item("z", 1'b0));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[n]) begin
      t = dir_tab[n];
      if (t.is_reg) begin
        stop_input();
        settle();
        write_reg(t.idx, t.val);
      end else begin
        send_item(t.ch, t.eot, t.n_typed > 0);
        for (int i = 0; i < t.n_typed; i++) begin
          o.letter = CipherW'(t.typed_letters[8*(t.n_typed-1-i) +: 8]);
          o.last_of_block = (i == t.n_typed - 1);
          o.end_of_msg = t.typed_eom && (i == t.n_typed - 1);
          cipher_due.push_back(o);
        end
      end
    end

    // Random part: each phase loads a block size and a key, then streams mostly
    // lowercase text with scattered other bytes and message ends.
    held_off = 1'b0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      stop_input();
      settle();
      case (phase)
        0: write_reg(RegBlockSize, KeyW'(1));
        1: write_reg(RegBlockSize, KeyW'(4));
        2: write_reg(RegBlockSize, KeyW'(0));
        3: write_reg(RegBlockSize, KeyW'(7));
        4: write_reg(RegBlockSize, KeyW'(3));
        default: write_reg(RegBlockSize, KeyW'($urandom_range(0, 7)));
      endcase
      for (int r = 0; r < KeyDim; r++) begin
        case (phase)
          1: kv = '0;
          2: kv = '1;
          0, 3: begin
            for (int c = 0; c < KeyDim; c++)
              kv[LetterW*c +: LetterW] = LetterW'($urandom_range(0, Modulus - 1));
          end
          default: kv = KeyW'($urandom());
        endcase
        write_reg(key_reg(r), kv);
      end
      steady_send = (phase == 4);
      counted = 0;
      while (counted < PhaseItems) begin
        // Once mid-stream, hold the sender back until the output has drained.
        if (phase == 2 && counted == PhaseItems / 2 && !held_off) begin
          held_off = 1'b1;
          stop_input();
          while (cipher_due.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        if (pick < 72) ch = CharW'(int'(AsciiA) + $urandom_range(0, 25));
        else ch = CharW'($urandom_range(0, 255));
        eot = ($urandom_range(0, 9) == 0);
        send_item(ch, eot, 1'b0);
        counted++;
      end
    end

    stop_input();
    settle();

    $display("Sent %0d text bytes and checked %0d cipher letters, %0d of them ending a message.",
             items_sent, letters_checked, eom_seen);
    $display("Block size values written (bit per value): %b; keys were identity, zero, all ones and random.",
             sizes_used);
    if (mismatches == 0 && cipher_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d letters still owed", mismatches, cipher_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
